// File: design/tms_pkg.sv
package tms_pkg;

  // default sizes of the stores
  localparam int MAX_STATES_DEF  = 128;
  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int TAPE_CELLS_DEF  = 128;

  // configuration register indexes and reset values
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 8;
  localparam logic [CFG_AW-1:0] CFG_STATE_COUNT  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SYMBOL_COUNT = 1'b1;
  localparam logic [7:0] STATE_COUNT_RST  = 8'd128;
  localparam logic [6:0] SYMBOL_COUNT_RST = 7'd64;

  // commands
  localparam logic [2:0] CMD_LOAD_ALPHA = 3'd0;
  localparam logic [2:0] CMD_LOAD_RULE  = 3'd1;
  localparam logic [2:0] CMD_LOAD_TAPE  = 3'd2;
  localparam logic [2:0] CMD_RESTART    = 3'd3;
  localparam logic [2:0] CMD_STEP       = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_HALTED  = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  // action and tape characters
  localparam logic [7:0] ACT_LEFT   = 8'h4C;
  localparam logic [7:0] ACT_RIGHT  = 8'h52;
  localparam logic [7:0] BLANK_MARK = 8'h23;
  localparam logic [7:0] EMPTY_CHAR = 8'h00;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] symbol_index;
    logic [6:0] state_index;
    logic [6:0] position;
    logic [7:0] char_value;
    logic [7:0] next_state_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        halted;
    logic [7:0]  machine_state;
    logic [6:0]  head_position;
    logic [7:0]  head_char;
    logic [31:0] step_total;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic capture;
    logic exec;
    logic scan;
    logic apply;
    logic fix;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic exec_restart;
    logic exec_run;
    logic scan_hit;
    logic scan_miss;
    logic apply_move;
  } stat_t;

endpackage

// File: design/turing_machine_stepper_top.sv
// Turing machine stepper. A command is taken when start_i is high and busy_o is low; its
// result is shown on res_o for exactly one cycle with done_o high and cannot be held off,
// so the receiver must take it then. After reset the alphabet and tape stores are cleared,
// one entry per cycle, over max(TAPE_CELLS, MAX_SYMBOLS) entries (128 by default), busy_o
// high; configuration writes are taken during that time. Loads and out-of-range commands
// go from execute straight to the result; a restart first reads the cell under the new head.
// A step searches the alphabet one slot per cycle through its memory port until a hit or
// min(symbol_count, MAX_SYMBOLS) slots, reads and applies the rule, and reads the new cell
// when the head moves; an unknown symbol ends the search, a halted step skips it.
module turing_machine_stepper_top
  import tms_pkg::*;
#(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int TAPE_CELLS  = TAPE_CELLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              start_i,
  input  in_item_t          item_i,
  output logic              busy_o,
  output logic              done_o,
  output out_item_t         res_o
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  tms_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  // stores and machine registers
  tms_datapath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .TAPE_CELLS  (TAPE_CELLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

// File: design/tms_ram.sv
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/tms_ctrl.sv
module tms_ctrl
  import tms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output logic  done_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_EXEC    = 9'b000000100,
    ST_SCAN    = 9'b000001000,
    ST_RULE_RD = 9'b000010000,
    ST_APPLY   = 9'b000100000,
    ST_TAPE_RD = 9'b001000000,
    ST_TAPE_FX = 9'b010000000,
    ST_RESP    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (stat_i.exec_restart) state_d = ST_TAPE_RD;
        else if (stat_i.exec_run) state_d = ST_SCAN;
        else state_d = ST_RESP;
      end
      ST_SCAN: begin
        priority if (stat_i.scan_hit) state_d = ST_RULE_RD;
        else if (stat_i.scan_miss) state_d = ST_RESP;
        else state_d = ST_SCAN;
      end
      ST_RULE_RD: state_d = ST_APPLY;
      ST_APPLY: begin
        state_d = stat_i.apply_move ? ST_TAPE_RD : ST_RESP;
      end
      ST_TAPE_RD: state_d = ST_TAPE_FX;
      ST_TAPE_FX: state_d = ST_RESP;
      ST_RESP:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  always_comb begin
    ctrl_o.clear   = (state_q == ST_CLEAR);
    ctrl_o.capture = (state_q == ST_IDLE) && start_i;
    ctrl_o.exec    = (state_q == ST_EXEC);
    ctrl_o.scan    = (state_q == ST_SCAN);
    ctrl_o.apply   = (state_q == ST_APPLY);
    ctrl_o.fix     = (state_q == ST_TAPE_FX);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_EXEC)
    else $error("accepted item did not enter execution");

  a_hit_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && stat_i.scan_hit) |=> state_q == ST_RULE_RD)
    else $error("alphabet hit did not start rule read");

  a_resp_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe not a single cycle");

endmodule

// File: design/tms_datapath.sv
module tms_datapath
  import tms_pkg::*;
#(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int TAPE_CELLS  = TAPE_CELLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  in_item_t          item_i,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  output out_item_t         res_o
);

  localparam int AW    = $clog2(MAX_SYMBOLS);
  localparam int SW    = $clog2(MAX_STATES);
  localparam int TW    = $clog2(TAPE_CELLS);
  localparam int NW    = $clog2(MAX_SYMBOLS + 1);
  localparam int RD    = MAX_SYMBOLS << SW;
  localparam int CLR_N = (TAPE_CELLS > MAX_SYMBOLS) ? TAPE_CELLS : MAX_SYMBOLS;
  localparam int CLRW  = $clog2(CLR_N);

  logic [7:0]      state_count_q;
  logic [6:0]      symbol_count_q;
  in_item_t        item_q;
  logic [7:0]      state_q, state_d;
  logic [TW-1:0]   head_q, head_d;
  logic [31:0]     steps_q, steps_d;
  logic            err_q, err_d;
  logic [7:0]      cur_q, cur_d;
  logic [1:0]      status_q, status_d;
  logic            fill_q, fill_d;
  logic [NW-1:0]   scan_idx_q, scan_idx_d;
  logic [NW-1:0]   prev_idx_q, prev_idx_d;
  logic            prev_vld_q, prev_vld_d;
  logic            first_q, first_d;
  logic [CLRW-1:0] clr_cnt_q;

  logic [7:0]    live_states;
  logic [NW-1:0] live_syms;
  logic          halted;
  logic          sym_ok, st_ok, pos_ok;
  logic [1:0]    exec_status;
  logic          scan_more;

  logic          alpha_we;
  logic [AW-1:0] alpha_waddr;
  logic [7:0]    alpha_wdata, alpha_rdata;
  logic          rule_we;
  logic [AW+SW-1:0] rule_waddr, rule_raddr;
  logic [15:0]   rule_wdata, rule_rdata;
  logic          tape_we;
  logic [TW-1:0] tape_waddr;
  logic [7:0]    tape_wdata, tape_rdata;

  logic [7:0] act, nxt;
  logic       is_left, is_right, can_left, can_right;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q  <= STATE_COUNT_RST;
      symbol_count_q <= SYMBOL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_STATE_COUNT:  state_count_q  <= cfg_wdata_i;
        CFG_SYMBOL_COUNT: symbol_count_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= item_i;
    end
  end

  // live counts and halt condition
  assign live_states = (state_count_q < 8'(MAX_STATES)) ? state_count_q : 8'(MAX_STATES);
  assign live_syms   = (9'(symbol_count_q) < 9'(MAX_SYMBOLS)) ? NW'(symbol_count_q)
                                                              : NW'(MAX_SYMBOLS);
  assign halted      = err_q || (state_q >= live_states);

  // range checks of the captured item
  assign sym_ok = 32'(item_q.symbol_index) < 32'(MAX_SYMBOLS);
  assign st_ok  = 32'(item_q.state_index) < 32'(MAX_STATES);
  assign pos_ok = 32'(item_q.position) < 32'(TAPE_CELLS);

  always_comb begin
    exec_status = STAT_RANGE;
    unique case (item_q.command)
      CMD_LOAD_ALPHA: exec_status = sym_ok ? STAT_DONE : STAT_RANGE;
      CMD_LOAD_RULE:  exec_status = (sym_ok && st_ok) ? STAT_DONE : STAT_RANGE;
      CMD_LOAD_TAPE:  exec_status = pos_ok ? STAT_DONE : STAT_RANGE;
      CMD_RESTART:    exec_status = pos_ok ? STAT_DONE : STAT_RANGE;
      CMD_STEP:       exec_status = halted ? STAT_HALTED : STAT_DONE;
      default:        exec_status = STAT_RANGE;
    endcase
  end

  // rule action decode
  assign act       = rule_rdata[7:0];
  assign nxt       = rule_rdata[15:8];
  assign is_left   = (act == ACT_LEFT);
  assign is_right  = (act == ACT_RIGHT);
  assign can_left  = (head_q != '0);
  assign can_right = (head_q != TW'(TAPE_CELLS - 1));
  assign scan_more = (scan_idx_q < live_syms);

  // status to controller
  always_comb begin
    stat_o.clr_last     = (clr_cnt_q == CLRW'(CLR_N - 1));
    stat_o.exec_restart = (item_q.command == CMD_RESTART) && pos_ok;
    stat_o.exec_run     = (item_q.command == CMD_STEP) && !halted;
    stat_o.scan_hit     = prev_vld_q && (cur_q != EMPTY_CHAR) && (alpha_rdata == cur_q);
    stat_o.scan_miss    = !first_q && !prev_vld_q;
    stat_o.apply_move   = (is_left && can_left) || (is_right && can_right);
  end

  // alphabet store: clearing pass and loads
  assign alpha_we    = (ctrl_i.clear && (32'(clr_cnt_q) < 32'(MAX_SYMBOLS)))
                    || (ctrl_i.exec && item_q.command == CMD_LOAD_ALPHA && sym_ok);
  assign alpha_waddr = ctrl_i.clear ? AW'(clr_cnt_q) : AW'(item_q.symbol_index);
  assign alpha_wdata = ctrl_i.clear ? EMPTY_CHAR : item_q.char_value;

  // rule table: loads, read at hit symbol and current state
  assign rule_we    = ctrl_i.exec && item_q.command == CMD_LOAD_RULE && sym_ok && st_ok;
  assign rule_waddr = {AW'(item_q.symbol_index), SW'(item_q.state_index)};
  assign rule_wdata = {item_q.next_state_value, item_q.char_value};
  assign rule_raddr = {AW'(prev_idx_q), SW'(state_q)};

  // tape write port arbitration
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head_q;
    tape_wdata = EMPTY_CHAR;
    priority if (ctrl_i.clear) begin
      tape_we    = (32'(clr_cnt_q) < 32'(TAPE_CELLS));
      tape_waddr = TW'(clr_cnt_q);
    end else if (ctrl_i.exec && item_q.command == CMD_LOAD_TAPE && pos_ok) begin
      tape_we    = 1'b1;
      tape_waddr = TW'(item_q.position);
      tape_wdata = item_q.char_value;
    end else if (ctrl_i.apply && !is_left && !is_right) begin
      tape_we    = 1'b1;
      tape_wdata = act;
    end else if (ctrl_i.fix && fill_q && tape_rdata == EMPTY_CHAR) begin
      tape_we    = 1'b1;
      tape_wdata = BLANK_MARK;
    end else begin
      tape_we = 1'b0;
    end
  end

  // machine registers
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    steps_d    = steps_q;
    err_d      = err_q;
    cur_d      = cur_q;
    status_d   = status_q;
    fill_d     = fill_q;
    scan_idx_d = scan_idx_q;
    prev_idx_d = prev_idx_q;
    prev_vld_d = prev_vld_q;
    first_d    = first_q;

    if (ctrl_i.exec) begin
      status_d   = exec_status;
      scan_idx_d = '0;
      prev_vld_d = 1'b0;
      first_d    = 1'b1;
      fill_d     = 1'b0;
      if (stat_o.exec_restart) begin
        head_d  = TW'(item_q.position);
        state_d = '0;
        steps_d = '0;
        err_d   = 1'b0;
      end
      if (item_q.command == CMD_LOAD_TAPE && pos_ok && TW'(item_q.position) == head_q) begin
        cur_d = item_q.char_value;
      end
    end

    // pipelined alphabet search, one slot per cycle; the hit slot is kept for the rule read
    if (ctrl_i.scan) begin
      first_d    = 1'b0;
      prev_vld_d = scan_more;
      if (!stat_o.scan_hit) prev_idx_d = scan_idx_q;
      scan_idx_d = scan_idx_q + NW'(scan_more);
      if (stat_o.scan_miss) begin
        err_d    = 1'b1;
        status_d = STAT_UNKNOWN;
      end
    end

    if (ctrl_i.apply) begin
      state_d = nxt;
      steps_d = (steps_q == '1) ? steps_q : steps_q + 32'd1;
      fill_d  = is_right && can_right;
      priority if (is_left) begin
        if (can_left) head_d = head_q - TW'(1);
      end else if (is_right) begin
        if (can_right) head_d = head_q + TW'(1);
      end else begin
        cur_d = act;
      end
    end

    if (ctrl_i.fix) begin
      cur_d = (fill_q && tape_rdata == EMPTY_CHAR) ? BLANK_MARK : tape_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      head_q     <= '0;
      steps_q    <= '0;
      err_q      <= 1'b0;
      cur_q      <= EMPTY_CHAR;
      status_q   <= STAT_DONE;
      fill_q     <= 1'b0;
      scan_idx_q <= '0;
      prev_idx_q <= '0;
      prev_vld_q <= 1'b0;
      first_q    <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      steps_q    <= steps_d;
      err_q      <= err_d;
      cur_q      <= cur_d;
      status_q   <= status_d;
      fill_q     <= fill_d;
      scan_idx_q <= scan_idx_d;
      prev_idx_q <= prev_idx_d;
      prev_vld_q <= prev_vld_d;
      first_q    <= first_d;
      if (ctrl_i.clear) clr_cnt_q <= clr_cnt_q + CLRW'(1);
    end
  end

  // stores
  tms_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (alpha_we),
    .waddr_i (alpha_waddr),
    .wdata_i (alpha_wdata),
    .raddr_i (AW'(scan_idx_q)),
    .rdata_o (alpha_rdata)
  );

  tms_ram #(.WIDTH(16), .DEPTH(RD)) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (rule_waddr),
    .wdata_i (rule_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  tms_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (head_q),
    .rdata_o (tape_rdata)
  );

  // result fields
  always_comb begin
    res_o.status        = status_q;
    res_o.halted        = halted;
    res_o.machine_state = state_q;
    res_o.head_position = 7'(head_q);
    res_o.head_char     = cur_q;
    res_o.step_total    = steps_q;
  end

  a_steps_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.exec |=> steps_q >= $past(steps_q))
    else $error("step count went down without restart");

  a_left_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && is_left && can_left) |=> head_q == $past(head_q) - TW'(1))
    else $error("left action did not move head");

  a_fill_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fix && fill_q && tape_rdata == EMPTY_CHAR) |=> cur_q == BLANK_MARK)
    else $error("empty cell after right move not marked");

endmodule
